// ===== src/adaptive_scale_governor_defines.svh =====
// Assertion macros for the adaptive scale governor.
// Used by the top level; it needs clk and arst_n in scope.
`ifndef ADAPTIVE_SCALE_GOVERNOR_DEFINES_SVH
`define ADAPTIVE_SCALE_GOVERNOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/asg_pkg.sv =====
// Shared types, constants and table functions of the adaptive scale governor.
// No dependencies; imported by every module of the block.
package asg_pkg;

	localparam int NUM_LEVELS_DEF = 4;
	localparam int LVL_W = 3;

	localparam int DVD_W = 38;
	localparam int DVS_W = 20;
	localparam int MA_W = 20;
	localparam int MB_W = 16;
	localparam int MP_W = MA_W + MB_W;

	localparam logic [17:0] EV_CLAMP = 18'd250000;
	localparam logic [39:0] HOLD_US = 40'd1250000;
	localparam logic [39:0] COOL_US = 40'd1250000;
	localparam logic [39:0] EVAL_US = 40'd800000;
	localparam logic [39:0] NOBEN_US = 40'd4000000;
	localparam logic [31:0] DOWN_US = 32'd900000;
	localparam logic [31:0] GDOWN_US = 32'd500000;
	localparam logic [31:0] UP_US = 32'd4000000;

	localparam logic CFG_ENABLE = 1'b0;
	localparam logic CFG_PRESET = 1'b1;

	// Status flag bit positions.
	localparam int FB_VALID = 0;
	localparam int FB_UVALID = 1;
	localparam int FB_DEF = 2;
	localparam int FB_GEN = 3;
	localparam int FB_DPRESS = 4;
	localparam int FB_MISS = 5;
	localparam int FB_WSI = 6;
	localparam int FB_DROP = 7;
	localparam int FB_TRANS = 8;
	localparam int FB_CAD = 9;
	localparam int FB_TARG = 10;
	localparam int FB_MET = 11;

	typedef enum logic [3:0] {
		RSN_NONE = 4'd0,
		RSN_DISABLED = 4'd1,
		RSN_INVALID = 4'd2,
		RSN_TRANSITION = 4'd3,
		RSN_COOLDOWN = 4'd4,
		RSN_SMALL_FLOW = 4'd5,
		RSN_PRESSURE = 4'd6,
		RSN_GPRESSURE = 4'd7,
		RSN_EVALUATING = 4'd8,
		RSN_BENEFIT = 4'd9,
		RSN_REVERTED = 4'd10,
		RSN_NO_HEADROOM = 4'd11,
		RSN_HEADROOM = 4'd12
	} rsn_t;

	// Squared table scales (scale in units of 1/200, squared).
	localparam logic [15:0] SQ_TAB [3][8] = '{
		'{16'd40000, 16'd32400, 16'd25600, 16'd19600,
		  16'd19600, 16'd19600, 16'd19600, 16'd19600},
		'{16'd25600, 16'd19600, 16'd15625, 16'd12100,
		  16'd12100, 16'd12100, 16'd12100, 16'd12100},
		'{16'd12100, 16'd8100, 16'd4900, 16'd2500,
		  16'd2500, 16'd2500, 16'd2500, 16'd2500}
	};

	// Output scales in units of 1/65536, rounded to nearest.
	localparam logic [16:0] SCL_TAB [3][8] = '{
		'{17'd65536, 17'd58982, 17'd52429, 17'd45875,
		  17'd45875, 17'd45875, 17'd45875, 17'd45875},
		'{17'd52429, 17'd45875, 17'd40960, 17'd36045,
		  17'd36045, 17'd36045, 17'd36045, 17'd36045},
		'{17'd36045, 17'd29491, 17'd22938, 17'd16384,
		  17'd16384, 17'd16384, 17'd16384, 17'd16384}
	};

	function automatic logic [1:0] tab_row(logic [1:0] p);
		return (p == 2'd3) ? 2'd0 : p;
	endfunction

	function automatic logic [15:0] scale_sq(logic [1:0] p, logic [LVL_W-1:0] l);
		return SQ_TAB[tab_row(p)][l];
	endfunction

	function automatic logic [16:0] scale_val(logic [1:0] p, logic [LVL_W-1:0] l);
		return SCL_TAB[tab_row(p)][l];
	endfunction

	function automatic logic [39:0] sat40(logic [39:0] a, logic [39:0] b);
		logic [40:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[40] ? '1 : s[39:0];
	endfunction

	function automatic logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? '1 : s[31:0];
	endfunction

endpackage

// ===== src/adaptive_scale_governor.sv =====
// Adaptive scale governor: one observation in, one scale decision out.
// An item passes through the load and flow quotients, the multiplier products, the
// predicted-total quotient and the decision, each quotient taken by the shared divider.
// One item at a time; the next item is accepted the cycle after the result is registered,
// and a result is not registered while an earlier result is still stalled.
// Asynchronous active-low reset sets level 0, enable on, preset 0 and clears all timers.
module adaptive_scale_governor
	import asg_pkg::*;
#(
	parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [19:0] elapsed_us,
	input  logic [19:0] frame_budget_us,
	input  logic [19:0] total_time_us,
	input  logic [19:0] flow_time_us,
	input  logic [9:0]  gpu_usage_tenths,
	input  logic [15:0] output_rate,
	input  logic [15:0] source_rate,
	input  logic [15:0] loss_rate,
	input  logic [11:0] status_flags,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [16:0] scale,
	output logic [1:0]  level,
	output logic        changed,
	output logic [3:0]  reason_code,
	output logic [20:0] predicted_total_us,
	output logic [15:0] load_ratio,
	output logic [15:0] flow_ratio,
	output logic [9:0]  usage_reported,
	output logic [4:0]  pressure_bits
);

`include "adaptive_scale_governor_defines.svh"

	localparam logic [LVL_W:0] NUM_LV = (LVL_W + 1)'(NUM_LEVELS);
	localparam logic [LVL_W-1:0] LAST_LV = LVL_W'(NUM_LEVELS - 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DIVL = 6'b000010,
		S_DIVF = 6'b000100,
		S_MUL  = 6'b001000,
		S_DIVP = 6'b010000,
		S_DEC  = 6'b100000
	} state_t;

	state_t state_q;
	logic [2:0] mstep_q;

	// Configuration and governor state.
	logic             enable_q;
	logic [1:0]       preset_q;
	logic [LVL_W-1:0] level_q;
	logic [LVL_W-1:0] prior_q;
	logic [39:0]      obs_q, cool_q, hold_q, ts_q;
	logic [31:0]      pt_q, ht_q;
	logic             trial_q, ben_q;

	// Trial baseline, written before any read.
	logic [15:0] bld_q;
	logic [19:0] bflw_q, btot_q;
	logic [15:0] bsr_q, bor_q, bloss_q;
	logic [9:0]  buse_q;
	logic [3:0]  bflg_q;

	// Latched item and intermediate results.
	logic [19:0] el_q, bud_q, tot_q, flw_q;
	logic [9:0]  use_q;
	logic [15:0] or_q, sr_q, loss_q;
	logic [11:0] flg_q;
	logic        rst_q;
	logic [15:0] ld_q, fr_q;
	logic [20:0] pred_q;
	logic [MP_W-1:0] fdl_q, bc2_q, tc2_q;
	logic [MP_W:0]   num_q;

	// Output register.
	logic        out_valid_q;
	logic [16:0] scale_q;
	logic [1:0]  level_out_q;
	logic        chg_out_q;
	rsn_t        rsn_q;
	logic [20:0] pred_out_q;
	logic [15:0] ld_out_q, fr_out_q;
	logic [9:0]  use_out_q;
	logic [4:0]  pb_out_q;

	// Shared units.
	logic             div_start, div_done;
	logic [DVD_W-1:0] div_dvd, div_q;
	logic [DVS_W-1:0] div_dvs;
	logic [MA_W-1:0]  mul_a;
	logic [MB_W-1:0]  mul_b;
	logic [MP_W-1:0]  mul_p;
	logic [MP_W:0]    num_n;

	logic [15:0] c2, l2, h2, dl, dh;
	logic        commit;

	asg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_q)
	);

	asg_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	always_comb begin
		c2 = scale_sq(preset_q, level_q);
		l2 = scale_sq(preset_q, level_q + 1'b1);
		h2 = scale_sq(preset_q, level_q - 1'b1);
		dl = (c2 >= l2) ? c2 - l2 : '0;
		dh = (h2 >= c2) ? h2 - c2 : '0;
		num_n = {1'b0, tc2_q} + {1'b0, mul_p};
	end

	always_comb begin
		case (mstep_q)
			3'd0: begin
				mul_a = flw_q;
				mul_b = dl;
			end
			3'd1: begin
				mul_a = bud_q;
				mul_b = c2;
			end
			3'd2: begin
				mul_a = tot_q;
				mul_b = c2;
			end
			default: begin
				mul_a = flw_q;
				mul_b = dh;
			end
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_dvd = DVD_W'({total_time_us, 12'd0});
		div_dvs = frame_budget_us;
		case (state_q)
			S_IDLE: begin
				div_start = in_valid;
			end
			S_DIVL: begin
				div_start = div_done;
				div_dvd = DVD_W'({flw_q, 12'd0});
				div_dvs = bud_q;
			end
			S_MUL: begin
				div_start = (mstep_q == 3'd4);
				div_dvd = DVD_W'(num_n);
				div_dvs = DVS_W'(c2);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign commit = (state_q == S_DEC) && (!out_valid_q || !out_stall);

	// Decision for one item, evaluated in the decision cycle.
	logic [17:0]      ev;
	logic [39:0]      obs_n, cool_d, hold_d, ts_d, hd;
	logic [31:0]      pt_d, ht_d, acc_t, confirm;
	logic [LVL_W-1:0] level_d, prior_d;
	logic             trial_d, ben_d, base_we;
	logic             chg, evalb, glob, comp, wsi_b, def_b;
	rsn_t             rsn;
	logic [15:0]      ld_o, fr_o;
	logic [9:0]       ur_o;
	logic [20:0]      pred_o;
	logic             f_valid, f_uv, f_def, f_gen, f_dp, f_miss, f_wsi, f_drop;
	logic             f_trans, f_cad, f_targ, f_met;
	logic             gpu_hi, wsiflow, gonly, ghead, retained, can_raise, ben_any;
	logic             ob, sb, cb, wb, gb, small_fl;

	always_comb begin
		f_valid = flg_q[FB_VALID];
		f_uv = flg_q[FB_UVALID];
		f_def = flg_q[FB_DEF];
		f_gen = flg_q[FB_GEN];
		f_dp = flg_q[FB_DPRESS];
		f_miss = flg_q[FB_MISS];
		f_wsi = flg_q[FB_WSI];
		f_drop = flg_q[FB_DROP];
		f_trans = flg_q[FB_TRANS];
		f_cad = flg_q[FB_CAD];
		f_targ = flg_q[FB_TARG];
		f_met = flg_q[FB_MET];

		ev = (el_q > 20'(EV_CLAMP)) ? EV_CLAMP : el_q[17:0];
		obs_n = sat40(obs_q, 40'(ev));

		comp = f_gen && (f_dp || f_miss || (24'(tot_q) * 24'd10 >= 24'(bud_q) * 24'd9));
		gpu_hi = f_uv && (use_q >= 10'd960);
		wsiflow = f_wsi && gpu_hi && f_def;
		gonly = 1'b0;
		ghead = !f_uv || (use_q <= 10'd880);
		retained = !f_gen && f_uv && ghead && !f_def && !f_drop;
		can_raise = (level_q != '0);

		ob = bflg_q[0] && f_cad && (23'(or_q) * 23'd50 >= 23'(bor_q) * 23'd51);
		sb = (bsr_q != '0) && (23'(sr_q) * 23'd100 >= 23'(bsr_q) * 23'd103);
		cb = bflg_q[1] && f_gen && (!comp ||
			(19'(ld_q) * 19'd5 + 19'd1024 <= 19'(bld_q) * 19'd5) ||
			((25'(flw_q) * 25'd25 <= 25'(bflw_q) * 25'd22) &&
			 (25'(tot_q) * 25'd20 <= 25'(btot_q) * 25'd19)));
		wb = bflg_q[2] && (bloss_q != '0) && (18'(loss_q) * 18'd4 <= 18'(bloss_q) * 18'd3);
		gb = bflg_q[3] && f_uv && (11'(use_q) + 11'd30 <= 11'(buse_q));
		ben_any = ben_q || ob || sb || cb || wb || gb;

		level_d = level_q;
		prior_d = prior_q;
		cool_d = cool_q;
		hold_d = hold_q;
		ts_d = ts_q;
		pt_d = pt_q;
		ht_d = ht_q;
		trial_d = trial_q;
		ben_d = ben_q;
		base_we = 1'b0;
		chg = 1'b0;
		evalb = trial_q;
		glob = 1'b0;
		wsi_b = 1'b0;
		def_b = 1'b0;
		rsn = RSN_NONE;
		ld_o = '0;
		fr_o = '0;
		ur_o = '0;
		pred_o = '0;
		hd = sat40(obs_n, HOLD_US);
		acc_t = '0;
		confirm = DOWN_US;
		small_fl = 1'b0;

		if (rst_q) begin
			level_d = '0;
			cool_d = '0;
			hold_d = '0;
			ts_d = '0;
			pt_d = '0;
			ht_d = '0;
			trial_d = 1'b0;
			ben_d = 1'b0;
			evalb = 1'b0;
			comp = 1'b0;
			rsn = enable_q ? RSN_NONE : RSN_DISABLED;
		end else if (!enable_q) begin
			comp = 1'b0;
			rsn = RSN_DISABLED;
		end else if (!f_valid || bud_q == '0) begin
			comp = 1'b0;
			if (trial_q) begin
				ts_d = sat40(ts_q, 40'(ev));
			end
			pt_d = '0;
			ht_d = '0;
			rsn = RSN_INVALID;
		end else begin
			ld_o = ld_q;
			fr_o = fr_q;
			ur_o = f_uv ? use_q : '0;
			glob = gpu_hi && (f_def || f_drop);
			gonly = glob && !comp;
			wsi_b = f_wsi;
			def_b = f_def;
			if (f_trans || obs_n < hold_q) begin
				if (trial_q) begin
					ts_d = sat40(ts_q, 40'(ev));
				end
				if (f_trans && hd > hold_q) begin
					hold_d = hd;
				end
				ht_d = '0;
				pt_d = glob ? sat32(pt_q, 32'(ev)) : '0;
				rsn = RSN_TRANSITION;
			end else if (trial_q) begin
				ben_d = ben_any;
				pt_d = '0;
				ht_d = '0;
				// The span is zero when the trial start lies ahead of observed time.
				if ({1'b0, obs_n} < {1'b0, ts_q} + {1'b0, EVAL_US}) begin
					evalb = 1'b1;
					rsn = RSN_EVALUATING;
				end else begin
					trial_d = 1'b0;
					evalb = 1'b0;
					if (ben_any) begin
						ben_d = 1'b0;
						rsn = RSN_BENEFIT;
					end else begin
						level_d = (prior_q < LAST_LV) ? prior_q : LAST_LV;
						chg = 1'b1;
						rsn = RSN_REVERTED;
						cool_d = sat40(obs_n, NOBEN_US);
					end
				end
			end else if (obs_n < cool_q) begin
				pt_d = '0;
				ht_d = '0;
				rsn = RSN_COOLDOWN;
			end else if ((comp || glob || wsiflow) && ({1'b0, level_q} + 1'b1 < NUM_LV)) begin
				small_fl = (24'(flw_q) * 24'd10 < 24'(bud_q)) ||
					(44'(fdl_q) * 44'd100 < 44'(bc2_q) * 44'd3) ||
					(gonly && (24'(tot_q) * 24'd10 < 24'(bud_q) * 24'd4));
				if (small_fl) begin
					pt_d = '0;
					ht_d = '0;
					rsn = RSN_SMALL_FLOW;
				end else begin
					acc_t = sat32(pt_q, 32'(ev));
					ht_d = '0;
					confirm = glob ? GDOWN_US : DOWN_US;
					if (acc_t >= confirm) begin
						trial_d = 1'b1;
						ben_d = 1'b0;
						prior_d = level_q;
						ts_d = obs_n;
						base_we = 1'b1;
						level_d = level_q + 1'b1;
						chg = 1'b1;
						evalb = 1'b1;
						rsn = glob ? RSN_GPRESSURE : RSN_PRESSURE;
						cool_d = sat40(obs_n, COOL_US);
						pt_d = '0;
					end else begin
						pt_d = acc_t;
					end
				end
			end else begin
				pt_d = '0;
				if (can_raise && !f_miss && (f_gen || retained) && !f_def && !f_drop &&
					!f_wsi && (!f_targ || f_met) && ghead) begin
					pred_o = pred_q;
					if (45'(num_q) * 45'd100 > 45'(bc2_q) * 45'd82) begin
						ht_d = '0;
						rsn = RSN_NO_HEADROOM;
					end else begin
						acc_t = sat32(ht_q, 32'(ev));
						if (acc_t >= UP_US) begin
							level_d = level_q - 1'b1;
							chg = 1'b1;
							rsn = RSN_HEADROOM;
							cool_d = sat40(obs_n, COOL_US);
							ht_d = '0;
						end else begin
							ht_d = acc_t;
						end
					end
				end else begin
					ht_d = '0;
					rsn = can_raise ? RSN_NO_HEADROOM : RSN_NONE;
				end
			end
		end
	end

	// Sequencer, governor state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mstep_q <= '0;
			out_valid_q <= 1'b0;
			enable_q <= 1'b1;
			preset_q <= '0;
			level_q <= '0;
			prior_q <= '0;
			obs_q <= '0;
			cool_q <= '0;
			hold_q <= '0;
			ts_q <= '0;
			pt_q <= '0;
			ht_q <= '0;
			trial_q <= 1'b0;
			ben_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !commit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DIVL;
					end
				end
				S_DIVL: begin
					if (div_done) begin
						state_q <= S_DIVF;
					end
				end
				S_DIVF: begin
					if (div_done) begin
						mstep_q <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == 3'd4) begin
						state_q <= S_DIVP;
					end
				end
				S_DIVP: begin
					if (div_done) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (commit) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
						level_q <= level_d;
						prior_q <= prior_d;
						if (!rst_q && enable_q) begin
							obs_q <= obs_n;
						end else if (rst_q) begin
							obs_q <= '0;
						end
						cool_q <= cool_d;
						hold_q <= hold_d;
						ts_q <= ts_d;
						pt_q <= pt_d;
						ht_q <= ht_d;
						trial_q <= trial_d;
						ben_q <= ben_d;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENABLE: begin
						if (cfg_data[0] != enable_q) begin
							enable_q <= cfg_data[0];
							level_q <= '0;
							obs_q <= '0;
							cool_q <= '0;
							hold_q <= '0;
							ts_q <= '0;
							pt_q <= '0;
							ht_q <= '0;
							trial_q <= 1'b0;
							ben_q <= 1'b0;
						end
					end
					CFG_PRESET: begin
						if (cfg_data != preset_q) begin
							preset_q <= cfg_data;
							level_q <= '0;
							obs_q <= '0;
							cool_q <= '0;
							hold_q <= '0;
							ts_q <= '0;
							pt_q <= '0;
							ht_q <= '0;
							trial_q <= 1'b0;
							ben_q <= 1'b0;
						end
					end
					default: begin
						enable_q <= enable_q;
					end
				endcase
			end
		end
	end

	// Item payload, intermediate results, baseline and output payload.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			el_q <= elapsed_us;
			bud_q <= frame_budget_us;
			tot_q <= total_time_us;
			flw_q <= flow_time_us;
			use_q <= gpu_usage_tenths;
			or_q <= output_rate;
			sr_q <= source_rate;
			loss_q <= loss_rate;
			flg_q <= status_flags;
			rst_q <= restart;
		end
		if (state_q == S_DIVL && div_done) begin
			ld_q <= (div_q > DVD_W'(16'hFFFF)) ? 16'hFFFF : div_q[15:0];
		end
		if (state_q == S_DIVF && div_done) begin
			fr_q <= (div_q > DVD_W'(16'hFFFF)) ? 16'hFFFF : div_q[15:0];
		end
		if (state_q == S_MUL) begin
			case (mstep_q)
				3'd1: fdl_q <= mul_p;
				3'd2: bc2_q <= mul_p;
				3'd3: tc2_q <= mul_p;
				3'd4: num_q <= num_n;
				default: begin
				end
			endcase
		end
		if (state_q == S_DIVP && div_done) begin
			pred_q <= (div_q > DVD_W'(21'h1FFFFF)) ? 21'h1FFFFF : div_q[20:0];
		end
		if (commit && base_we) begin
			bld_q <= ld_q;
			bflw_q <= flw_q;
			btot_q <= tot_q;
			bsr_q <= sr_q;
			bor_q <= or_q;
			bloss_q <= loss_q;
			buse_q <= use_q;
			bflg_q <= {glob, f_wsi, comp, f_cad};
		end
		if (commit) begin
			scale_q <= scale_val(preset_q, level_d);
			level_out_q <= level_d[1:0];
			chg_out_q <= chg;
			rsn_q <= rsn;
			pred_out_q <= pred_o;
			ld_out_q <= ld_o;
			fr_out_q <= fr_o;
			use_out_q <= ur_o;
			pb_out_q <= {evalb, def_b, wsi_b, comp, glob};
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign scale = scale_q;
	assign level = level_out_q;
	assign changed = chg_out_q;
	assign reason_code = rsn_q;
	assign predicted_total_us = pred_out_q;
	assign load_ratio = ld_out_q;
	assign flow_ratio = fr_out_q;
	assign usage_reported = use_out_q;
	assign pressure_bits = pb_out_q;

	// A trial only exists after a step down, so the level cannot be level zero.
	`ASG_ASSERT_SAME(a_trial_level, trial_q, level_q != '0, "trial active at level zero")
	`ASG_ASSERT_NEXT(a_commit_out, commit, out_valid_q && state_q == S_IDLE, "commit lost")
	`ASG_ASSERT_SAME(a_change_reason, out_valid_q && chg_out_q,
		rsn_q == RSN_PRESSURE || rsn_q == RSN_GPRESSURE || rsn_q == RSN_REVERTED ||
		rsn_q == RSN_HEADROOM, "level change without a changing reason")
	`ASG_ASSERT_SAME(a_level_range, state_q == S_IDLE, {1'b0, level_q} < NUM_LV,
		"level beyond table")

endmodule

// ===== src/asg_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all quotients.
// Depends on asg_pkg for the operand widths.
module asg_div
	import asg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] acc_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   rem_sub;
	logic             qbit;

	always_comb begin
		rem_sh = {rem_q, acc_q[DVD_W-1]};
		qbit = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[DVD_W-2:0], qbit};
			rem_q <= qbit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = acc_q;

endmodule

// ===== src/asg_mul.sv =====
// Shared multiplier with a registered product.
// Depends on asg_pkg for the operand widths.
module asg_mul
	import asg_pkg::*;
(
	input  logic            clk,
	input  logic [MA_W-1:0] a,
	input  logic [MB_W-1:0] b,
	output logic [MP_W-1:0] p
);

	logic [MP_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= MP_W'(a) * MP_W'(b);
	end

	assign p = p_q;

endmodule
